// ===== rtl/accel_tilt_angle_smoother_defines.svh =====
// Assertion macros for the tilt-angle smoother checker.
`ifndef ACCEL_TILT_ANGLE_SMOOTHER_DEFINES_SVH
`define ACCEL_TILT_ANGLE_SMOOTHER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ATS_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ats: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define ATS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ats: next-cycle check failed");

`endif

// ===== rtl/ats_pkg.sv =====
package ats_pkg;

   localparam int ANGLE_ITERATIONS = 16;
   localparam int ATAN_TABLE_SIZE  = 24;
   localparam int ANGLE_STEPS      = (ANGLE_ITERATIONS > ATAN_TABLE_SIZE) ?
                                     ATAN_TABLE_SIZE : ANGLE_ITERATIONS;
   localparam int STEP_W           = $clog2(ANGLE_STEPS);
   localparam int ATAN_IDX_W       = $clog2(ATAN_TABLE_SIZE);
   localparam int ATAN_W           = 23;  // largest entry 2949120
   localparam int ANG_W            = 26;  // angle accumulator, 1/65536 deg
   localparam int XY_W             = 33;  // CORDIC vector, gain included
   localparam int PRESHIFT         = 14;
   localparam int AXIS_W           = 16;
   localparam int ANGLE_W          = 16;
   localparam int COUNT_W          = 16;
   localparam int WEIGHT_W         = 16;

   localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE       = 16'sd23040;
   localparam logic [WEIGHT_W-1:0]       KEEP_WEIGHT_RESET = 16'd58982;

   // atan(2^-i) in 1/65536 degree, rounded to nearest
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      unique case (idx)
         5'd0:    v = 23'd2949120;
         5'd1:    v = 23'd1740967;
         5'd2:    v = 23'd919879;
         5'd3:    v = 23'd466945;
         5'd4:    v = 23'd234379;
         5'd5:    v = 23'd117304;
         5'd6:    v = 23'd58666;
         5'd7:    v = 23'd29335;
         5'd8:    v = 23'd14668;
         5'd9:    v = 23'd7334;
         5'd10:   v = 23'd3667;
         5'd11:   v = 23'd1833;
         5'd12:   v = 23'd917;
         5'd13:   v = 23'd458;
         5'd14:   v = 23'd229;
         5'd15:   v = 23'd115;
         5'd16:   v = 23'd57;
         5'd17:   v = 23'd29;
         5'd18:   v = 23'd14;
         5'd19:   v = 23'd7;
         5'd20:   v = 23'd4;
         5'd21:   v = 23'd2;
         5'd22:   v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/accel_tilt_angle_smoother.sv =====
// Accelerometer tilt-angle smoother. Each req transaction carries one x/y/z
// sample; each rsp transaction returns the smoothed pitch = atan(z/y) and
// roll = atan(x/y) in signed 1/256 degree (range -90..+90 degrees, y = 0
// gives +/-90 by the numerator's sign, or 0) and a sample count that
// saturates at 65535. The first sample, and any sample seen while both
// stored angles are zero, is loaded without smoothing; otherwise
// avg = round(avg*w + new*(1-w)), w = keep_weight/65536 (reset 58982),
// written through the csr port while the block is idle (the user's duty; the
// block itself does not enforce it). Timing: each sample runs 16 iterations
// of two CORDIC units side by side, a rounding step, the bit-serial smoothing
// multiply (one weight bit per cycle), and the load of the result.
// req_tready comes back in the same cycle that rsp_tvalid rises, so no new
// sample is taken until the last one is loaded. A result left waiting in the
// rsp register does not stop the next sample from being taken; that sample
// only holds before its load.
module accel_tilt_angle_smoother (
   input  logic                         clock,
   input  logic                         reset,
   // configuration: keep_weight
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ats_pkg::WEIGHT_W-1:0] csr_data,
   // sample in
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [47:0]                  req_tdata,   // accel_x, accel_y, accel_z
   // result out
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [47:0]                  rsp_tdata    // pitch_avg, roll_avg, sample_count
);

   typedef enum logic [1:0] {ST_IDLE, ST_ANGLE, ST_SMOOTH, ST_DONE} state_type;

   localparam int PROD_W = ats_pkg::ANGLE_W + 2;  // serial product high part
   localparam int BIT_W  = $clog2(ats_pkg::WEIGHT_W);

   state_type                              state_ff, state_in;
   logic [ats_pkg::WEIGHT_W-1:0]           keep_weight_ff, keep_weight_in;
   logic [ats_pkg::WEIGHT_W-1:0]           weight_sr_ff, weight_sr_in;
   logic [BIT_W-1:0]                       bit_cnt_ff, bit_cnt_in;
   logic signed [PROD_W-1:0]               pitch_hi_ff, pitch_hi_in;
   logic signed [PROD_W-1:0]               roll_hi_ff, roll_hi_in;
   logic [ats_pkg::WEIGHT_W-1:0]           pitch_lo_ff, pitch_lo_in;
   logic [ats_pkg::WEIGHT_W-1:0]           roll_lo_ff, roll_lo_in;
   logic signed [ats_pkg::ANGLE_W-1:0]     pitch_store_ff, pitch_store_in;
   logic signed [ats_pkg::ANGLE_W-1:0]     roll_store_ff, roll_store_in;
   logic [ats_pkg::COUNT_W-1:0]            count_store_ff, count_store_in;
   logic                                   rsp_valid_ff, rsp_valid_in;

   logic                                   start;
   logic                                   pitch_done, roll_done;
   logic signed [ats_pkg::ANGLE_W-1:0]     pitch_new, roll_new;
   logic signed [ats_pkg::ANGLE_W:0]       pitch_diff, roll_diff;
   logic signed [PROD_W-1:0]               pitch_t, roll_t;
   logic signed [PROD_W-1:0]               pitch_avg, roll_avg;

   // both angles computed in parallel
   assign start = req_tvalid && req_tready;

   ats_cordic u_pitch (
      .clock (clock),
      .reset (reset),
      .start (start),
      .num   (req_tdata[47:32]),
      .den   (req_tdata[31:16]),
      .done  (pitch_done),
      .angle (pitch_new)
   );

   ats_cordic u_roll (
      .clock (clock),
      .reset (reset),
      .start (start),
      .num   (req_tdata[15:0]),
      .den   (req_tdata[31:16]),
      .done  (roll_done),
      .angle (roll_new)
   );

   // avg = (old-new)*w/65536 + new, rounded: serial multiply, LSB of w first;
   // low product bits shift out into *_lo, rounding bit is lo[15]
   always_comb begin
      pitch_diff = (ats_pkg::ANGLE_W+1)'(pitch_store_ff) - (ats_pkg::ANGLE_W+1)'(pitch_new);
      roll_diff  = (ats_pkg::ANGLE_W+1)'(roll_store_ff) - (ats_pkg::ANGLE_W+1)'(roll_new);
      pitch_t    = pitch_hi_ff + (weight_sr_ff[0] ? PROD_W'(pitch_diff) : PROD_W'(0));
      roll_t     = roll_hi_ff + (weight_sr_ff[0] ? PROD_W'(roll_diff) : PROD_W'(0));
      pitch_avg  = pitch_hi_ff + PROD_W'(pitch_new)
                   + PROD_W'(pitch_lo_ff[ats_pkg::WEIGHT_W-1]);
      roll_avg   = roll_hi_ff + PROD_W'(roll_new)
                   + PROD_W'(roll_lo_ff[ats_pkg::WEIGHT_W-1]);
   end

   always_comb begin
      state_in       = state_ff;
      keep_weight_in = (csr_valid && csr_ready) ? csr_data : keep_weight_ff;
      weight_sr_in   = weight_sr_ff;
      bit_cnt_in     = bit_cnt_ff;
      pitch_hi_in    = pitch_hi_ff;
      roll_hi_in     = roll_hi_ff;
      pitch_lo_in    = pitch_lo_ff;
      roll_lo_in     = roll_lo_ff;
      pitch_store_in = pitch_store_ff;
      roll_store_in  = roll_store_ff;
      count_store_in = count_store_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            if (pitch_done && roll_done) begin
               state_in     = ST_SMOOTH;
               weight_sr_in = keep_weight_ff;
               bit_cnt_in   = '0;
               pitch_hi_in  = '0;
               roll_hi_in   = '0;
               pitch_lo_in  = '0;
               roll_lo_in   = '0;
            end
         end
         ST_SMOOTH: begin
            weight_sr_in = weight_sr_ff >> 1;
            pitch_hi_in  = pitch_t >>> 1;
            roll_hi_in   = roll_t >>> 1;
            pitch_lo_in  = {pitch_t[0], pitch_lo_ff[ats_pkg::WEIGHT_W-1:1]};
            roll_lo_in   = {roll_t[0], roll_lo_ff[ats_pkg::WEIGHT_W-1:1]};
            bit_cnt_in   = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_W'(ats_pkg::WEIGHT_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // stores double as the rsp register: update only once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (pitch_store_ff == '0 && roll_store_ff == '0) begin
                  pitch_store_in = pitch_new;
                  roll_store_in  = roll_new;
               end else begin
                  pitch_store_in = pitch_avg[ats_pkg::ANGLE_W-1:0];
                  roll_store_in  = roll_avg[ats_pkg::ANGLE_W-1:0];
               end
               if (count_store_ff != '1) begin
                  count_store_in = count_store_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         keep_weight_ff <= ats_pkg::KEEP_WEIGHT_RESET;
         pitch_store_ff <= '0;
         roll_store_ff  <= '0;
         count_store_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         keep_weight_ff <= keep_weight_in;
         pitch_store_ff <= pitch_store_in;
         roll_store_ff  <= roll_store_in;
         count_store_ff <= count_store_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      weight_sr_ff <= weight_sr_in;
      bit_cnt_ff   <= bit_cnt_in;
      pitch_hi_ff  <= pitch_hi_in;
      roll_hi_ff   <= roll_hi_in;
      pitch_lo_ff  <= pitch_lo_in;
      roll_lo_ff   <= roll_lo_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {count_store_ff, roll_store_ff, pitch_store_ff};

endmodule

// ===== rtl/ats_cordic.sv =====
// Iterative vectoring CORDIC: atan(|num|/|den|), signed, 1/256 degree.
module ats_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [ats_pkg::AXIS_W-1:0]    num,
   input  logic signed [ats_pkg::AXIS_W-1:0]    den,
   output logic                                 done,
   output logic signed [ats_pkg::ANGLE_W-1:0]   angle
);

   typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_FIN} state_type;

   state_type                               state_ff, state_in;
   logic [ats_pkg::STEP_W-1:0]              step_ff, step_in;
   logic signed [ats_pkg::XY_W-1:0]         xv_ff, xv_in, yv_ff, yv_in;
   logic signed [ats_pkg::ANG_W-1:0]        ang_ff, ang_in;
   logic                                    neg_ff, neg_in;
   logic                                    special_ff, special_in;
   logic signed [ats_pkg::ANGLE_W-1:0]      special_val_ff, special_val_in;
   logic signed [ats_pkg::ANGLE_W-1:0]      angle_ff, angle_in;

   logic signed [ats_pkg::AXIS_W:0]         num_ext, den_ext;
   logic [ats_pkg::AXIS_W:0]                num_mag, den_mag;
   logic signed [ats_pkg::XY_W-1:0]         xs, ys;
   logic signed [ats_pkg::ANG_W-1:0]        entry;
   logic signed [ats_pkg::ANG_W-1:0]        rsum, rshift;
   logic signed [ats_pkg::ANGLE_W-1:0]      mag;

   always_comb begin
      num_ext = (ats_pkg::AXIS_W+1)'(num);
      den_ext = (ats_pkg::AXIS_W+1)'(den);
      num_mag = num_ext[ats_pkg::AXIS_W] ? -num_ext : num_ext;
      den_mag = den_ext[ats_pkg::AXIS_W] ? -den_ext : den_ext;

      xs    = xv_ff >>> step_ff;
      ys    = yv_ff >>> step_ff;
      entry = ats_pkg::ANG_W'(ats_pkg::atan_entry(ats_pkg::ATAN_IDX_W'(step_ff)));

      // round half up to 1/256 degree, clamp to 0..90 degrees
      rsum   = ang_ff + ats_pkg::ANG_W'(128);
      rshift = rsum >>> 8;
      if (rshift[ats_pkg::ANG_W-1]) begin
         mag = '0;
      end else if (rshift > ats_pkg::ANG_W'(ats_pkg::RIGHT_ANGLE)) begin
         mag = ats_pkg::RIGHT_ANGLE;
      end else begin
         mag = rshift[ats_pkg::ANGLE_W-1:0];
      end

      state_in       = state_ff;
      step_in        = step_ff;
      xv_in          = xv_ff;
      yv_in          = yv_ff;
      ang_in         = ang_ff;
      neg_in         = neg_ff;
      special_in     = special_ff;
      special_val_in = special_val_ff;
      angle_in       = angle_ff;

      unique case (state_ff)
         CS_IDLE: begin
            if (start) begin
               state_in   = CS_RUN;
               step_in    = '0;
               xv_in      = ats_pkg::XY_W'(den_mag) <<< ats_pkg::PRESHIFT;
               yv_in      = ats_pkg::XY_W'(num_mag) <<< ats_pkg::PRESHIFT;
               ang_in     = '0;
               neg_in     = num[ats_pkg::AXIS_W-1] ^ den[ats_pkg::AXIS_W-1];
               special_in = (den == '0) || (num == '0);
               if (den == '0 && num != '0) begin
                  special_val_in = num[ats_pkg::AXIS_W-1] ? -ats_pkg::RIGHT_ANGLE
                                                          : ats_pkg::RIGHT_ANGLE;
               end else begin
                  special_val_in = '0;
               end
            end
         end
         CS_RUN: begin
            if (!yv_ff[ats_pkg::XY_W-1]) begin
               xv_in  = xv_ff + ys;
               yv_in  = yv_ff - xs;
               ang_in = ang_ff + entry;
            end else begin
               xv_in  = xv_ff - ys;
               yv_in  = yv_ff + xs;
               ang_in = ang_ff - entry;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == ats_pkg::STEP_W'(ats_pkg::ANGLE_STEPS - 1)) begin
               state_in = CS_FIN;
            end
         end
         CS_FIN: begin
            state_in = CS_IDLE;
            if (special_ff) begin
               angle_in = special_val_ff;
            end else begin
               angle_in = neg_ff ? -mag : mag;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff        <= step_in;
      xv_ff          <= xv_in;
      yv_ff          <= yv_in;
      ang_ff         <= ang_in;
      neg_ff         <= neg_in;
      special_ff     <= special_in;
      special_val_ff <= special_val_in;
      angle_ff       <= angle_in;
   end

   assign done  = (state_ff == CS_FIN);
   assign angle = angle_ff;

endmodule

// ===== rtl/ats_checker.sv =====
`include "accel_tilt_angle_smoother_defines.svh"

module ats_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // a stalled result transaction keeps its payload
   `ATS_ASSERT_NEXT(rsp_hold_a, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one sample at a time: busy right after taking one
   `ATS_ASSERT_NEXT(busy_after_req_a, req_tvalid && req_tready, !req_tready)

   // every result counts at least one sample
   `ATS_ASSERT_IMPLY(count_nonzero_a, rsp_tvalid, rsp_tdata[47:32] != 16'd0)

   // smoothed angles stay within +/-90 degrees
   `ATS_ASSERT_IMPLY(angle_range_a, rsp_tvalid,
      ($signed(rsp_tdata[15:0]) <= 16'sd23040) && ($signed(rsp_tdata[15:0]) >= -16'sd23040)
      && ($signed(rsp_tdata[31:16]) <= 16'sd23040)
      && ($signed(rsp_tdata[31:16]) >= -16'sd23040))

endmodule

bind accel_tilt_angle_smoother ats_checker u_ats_checker (.*);

// ===== tb/accel_tilt_angle_smoother_tb.sv =====
`timescale 1ns / 1ps

module accel_tilt_angle_smoother_tb;

   // Run-away guard, far above the slowest legal run (~1900 samples)
   localparam int CYCLE_LIMIT     = 500000;
   localparam int RSP_HOLD_CYCLES = 400;   // long receiver back-pressure stretch
   localparam int SETTLE_CYCLES   = 40;    // a bit more than one sample's latency

   // Keeps its own copy of the smoothed angles, the weight and the counter.
   // Each accepted sample queues the rsp transaction it must produce.
   class tilt_checker;
      typedef struct {
         int pitch;
         int roll;
         int count;
      } tilt_result_type;

      tilt_result_type pending_angles[$];
      int keep_weight;
      int pitch_avg;
      int roll_avg;
      int sample_count;
      int errors;

      function new();
         keep_weight  = ats_pkg::KEEP_WEIGHT_RESET;
         pitch_avg    = 0;
         roll_avg     = 0;
         sample_count = 0;
         errors       = 0;
      endfunction

      function void set_weight(input logic [ats_pkg::WEIGHT_W-1:0] w);
         keep_weight = w;
      endfunction

      function int pending();
         return pending_angles.size();
      endfunction

      // atan(|num|/|den|) by vectoring CORDIC, result in 1/256 degree, sign applied
      function longint cordic_tilt(input longint num, input longint den);
         longint lut[24] = '{
            2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0
         };
         longint an, ad, xv, yv, xs, ys, acc, r;
         bit neg;
         if (den == 0) begin
            return (num > 0) ? longint'(ats_pkg::RIGHT_ANGLE) :
                   (num < 0) ? -longint'(ats_pkg::RIGHT_ANGLE) : 0;
         end
         if (num == 0) begin
            return 0;
         end
         an  = (num < 0) ? -num : num;
         ad  = (den < 0) ? -den : den;
         neg = (num < 0) != (den < 0);
         xv  = ad <<< ats_pkg::PRESHIFT;
         yv  = an <<< ats_pkg::PRESHIFT;
         acc = 0;
         for (int i = 0; i < ats_pkg::ANGLE_STEPS; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
               xv  = xv + ys;
               yv  = yv - xs;
               acc = acc + lut[i];
            end else begin
               xv  = xv - ys;
               yv  = yv + xs;
               acc = acc - lut[i];
            end
         end
         r = (acc + 128) >>> 8;
         if (r < 0) begin
            r = 0;
         end
         if (r > ats_pkg::RIGHT_ANGLE) begin
            r = ats_pkg::RIGHT_ANGLE;
         end
         return neg ? -r : r;
      endfunction

      function int blend_angle(input int old_avg, input longint fresh);
         longint w, sum;
         w   = keep_weight;
         sum = longint'(old_avg) * w + fresh * (65536 - w) + 32768;
         return int'(sum >>> 16);
      endfunction

      function void note_sample(input logic signed [ats_pkg::AXIS_W-1:0] ax,
                                input logic signed [ats_pkg::AXIS_W-1:0] ay,
                                input logic signed [ats_pkg::AXIS_W-1:0] az);
         longint pitch_new, roll_new;
         tilt_result_type res;
         pitch_new = cordic_tilt(az, ay);
         roll_new  = cordic_tilt(ax, ay);
         if (pitch_avg == 0 && roll_avg == 0) begin
            pitch_avg = int'(pitch_new);
            roll_avg  = int'(roll_new);
         end else begin
            pitch_avg = blend_angle(pitch_avg, pitch_new);
            roll_avg  = blend_angle(roll_avg, roll_new);
         end
         if (sample_count < 65535) begin
            sample_count++;
         end
         res.pitch = pitch_avg;
         res.roll  = roll_avg;
         res.count = sample_count;
         pending_angles.push_back(res);
      endfunction

      task report_mismatch(input string what, input int got, input int want);
         $display("%0t MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check_result(input logic [47:0] data);
         tilt_result_type want;
         int got_pitch, got_roll, got_count;
         if (pending_angles.size() == 0) begin
            report_mismatch("unexpected result", int'(data[47:32]), -1);
            return;
         end
         want      = pending_angles.pop_front();
         got_pitch = $signed(data[15:0]);
         got_roll  = $signed(data[31:16]);
         got_count = data[47:32];
         if (got_pitch != want.pitch) begin
            report_mismatch("pitch_avg", got_pitch, want.pitch);
         end
         if (got_roll != want.roll) begin
            report_mismatch("roll_avg", got_roll, want.roll);
         end
         if (got_count != want.count) begin
            report_mismatch("sample_count", got_count, want.count);
         end
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;

   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [ats_pkg::WEIGHT_W-1:0] csr_data  = '0;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // accel_x, accel_y, accel_z

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // pitch_avg, roll_avg, sample_count

   tilt_checker sb;

   int   req_idle_pct = 0;    // chance per draw that the sender lengthens its gap before a sample
   int   rsp_idle_pct = 0;    // chance per cycle that the receiver stalls
   logic rsp_hold     = 1'b0;
   int   cycle_count  = 0;
   event hold_go;

   accel_tilt_angle_smoother u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: check every rsp transaction against the oldest expectation,
   // then pick next cycle's tready (random stall, or forced low during a hold).
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Long back-pressure: receiver stays off for a fixed stretch while the
   // sender keeps offering, so the block fills and drops req_tready.
   initial begin
      @(hold_go);
      rsp_hold <= 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // One req transaction; valid stays up back to back unless a gap is drawn.
   task automatic send_sample(input logic signed [ats_pkg::AXIS_W-1:0] ax,
                              input logic signed [ats_pkg::AXIS_W-1:0] ay,
                              input logic signed [ats_pkg::AXIS_W-1:0] az);
      int gap = 0;
      while ($urandom_range(99) < req_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {az, ay, ax};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(ax, ay, az);
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_weight(input logic [ats_pkg::WEIGHT_W-1:0] w);
      csr_valid <= 1'b1;
      csr_data  <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_weight(w);
   endtask

   // Axis value biased toward the interesting spots: zero, rails, +/-1, small
   function automatic logic signed [ats_pkg::AXIS_W-1:0] pick_axis();
      case ($urandom_range(9))
         0:       return '0;
         1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         2:       return $urandom_range(1) ? 16'sh0001 : 16'shFFFF;
         3, 4:    return 16'($urandom_range(64) - 32);
         default: return 16'($urandom());
      endcase
   endfunction

   // Random samples, with runs of all-zero samples mixed in so the smoothed
   // angles can decay to zero together and the next sample loads directly.
   // Halfway through, optionally start the receiver hold or pause the sender.
   task automatic run_random(input int n_items, input bit hold_mid, input bit pause_mid);
      int  sent = 0;
      int  burst;
      bit  mid_done = 1'b0;
      while (sent < n_items) begin
         if (!mid_done && sent >= n_items / 2) begin
            mid_done = 1'b1;
            if (hold_mid) begin
               -> hold_go;
            end
            if (pause_mid) begin
               drain();
            end
         end
         if ($urandom_range(99) < 6) begin
            burst = $urandom_range(12, 8);
            repeat (burst) send_sample(0, 0, 0);
            sent += burst;
         end else begin
            send_sample(pick_axis(), pick_axis(), pick_axis());
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sender idles 32%, receiver 50%
      req_idle_pct = 32;
      rsp_idle_pct = 50;

      // Directed, reset weight. First sample: both angles zero (y = 0, num = 0).
      send_sample(0, 0, 0);
      // y = 0 with numerator at the rails: +90 / -90, loaded directly
      send_sample(32767, 0, -32768);
      send_sample(-32768, 0, 32767);
      send_sample(0, 0, 1);
      send_sample(-1, 0, 0);
      // zero numerator, nonzero divisor
      send_sample(0, 100, 0);
      send_sample(0, -1, 0);
      // ratio extremes and sign combinations
      send_sample(32767, 1, -32768);
      send_sample(1, 32767, -1);
      send_sample(-32768, -32768, 32767);
      send_sample(32767, -32768, -32768);
      send_sample(-32768, 32767, -32768);
      send_sample(1000, 1000, -1000);
      send_sample(-1, -1, 1);
      send_sample(12345, -23456, -321);
      send_sample(-7, 3, 5);
      // alternating bit patterns
      send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
      send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);

      // Weight 0: average follows each new angle; includes the long receiver hold.
      drain();
      write_weight('0);
      run_random(450, 1'b1, 1'b0);
      send_sample(0, 0, 0);   // leave both stores at zero for the next phase

      // Weight max, idling swapped; sender pauses once until all results are back.
      drain();
      write_weight(16'hFFFF);
      req_idle_pct = 50;
      rsp_idle_pct = 32;
      run_random(450, 1'b0, 1'b1);

      // No idling from here on.
      drain();
      write_weight(16'd16384);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(450, 1'b0, 1'b0);

      drain();
      write_weight(16'($urandom_range(65535)));
      run_random(500, 1'b0, 1'b0);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
